FILE: sv/a8mab_pkg.sv
// Shared types, register indexes and pixel helpers for the A8 mask alpha blender.
package a8mab_pkg;

    typedef logic [7:0]  t_chan;
    typedef logic [15:0] t_sum;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd4;

    localparam logic FMT_RGB565   = 1'b0;
    localparam logic FMT_RGBA8888 = 1'b1;

    localparam t_chan ALPHA_RESET = 8'hFF;
    localparam t_chan CHAN_FULL   = 8'hFF;

    // Pack three 8-bit channels to RGB565 by truncation.
    function automatic logic [15:0] pack_565(input t_chan r, input t_chan g, input t_chan b);
        pack_565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

FILE: sv/a8mab_mix.sv
// One colour channel lane: registered mix sum, then rounding division by 255.
module a8mab_mix (
    input  logic              i_clk,
    input  logic              i_en,
    input  a8mab_pkg::t_chan  i_a,
    input  a8mab_pkg::t_chan  i_c,
    input  a8mab_pkg::t_chan  i_d,
    output a8mab_pkg::t_chan  o_q
);
    import a8mab_pkg::*;

    logic [16:0] n_sum;
    t_sum        r_sum;
    logic [16:0] w_div;

    // a*c + (255-a)*d + 127 never exceeds 65152
    always_comb begin
        n_sum = 17'(i_a) * 17'(i_c) + 17'(CHAN_FULL - i_a) * 17'(i_d) + 17'd127;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum[15:0];
        end
    end

    // exact x/255 for any x up to 65152, the largest sum above
    assign w_div = (17'(r_sum) + 17'(r_sum[15:8]) + 17'd1) >> 8;
    assign o_q   = w_div[7:0];

endmodule

FILE: sv/a8_mask_alpha_blend.sv
// Top level of the A8 coverage mask source-over blender (RGB565 / RGBA8888).
//
// Usage:
//   Input channel:  i_valid / o_stall carry i_mask_alpha and i_dst_pixel.
//   Output channel: o_valid / i_stall carry o_pixel_out and o_write_needed.
//   A transfer happens on a rising edge with valid high and stall low.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data;
//   o_cfg_ready is always high, indexes beyond the register list are dropped.
//   Write configuration only while the pipe is empty.
// Timing:
//   Three register stages (alpha product, channel mix sums, divide/pack into
//   the output register); o_valid is the valid bit of the third stage.
//   Throughput is one pixel per clock while i_stall is low, as every stage
//   is fully pipelined.
// Reset (i_rst_n low, synchronous): all stage valid bits clear, the colour
// resets to black, alpha to 255, format to RGB565.
// Stall: a stage advances when it is empty or the one after it moves, so a
// held output fills the pipe bubble-free; o_stall rises only once all three
// stages hold a pixel and i_stall is high. Nothing is dropped or repeated.
module a8_mask_alpha_blend (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_mask_alpha,
    input  logic [31:0]                         i_dst_pixel,
    // pixel output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [31:0]                         o_pixel_out,
    output logic                                o_write_needed,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [a8mab_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [a8mab_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import a8mab_pkg::*;

    // configuration registers
    logic  r_format;
    t_chan r_red, r_green, r_blue, r_alpha;

    // stage valid bits and advance control
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_en1, w_en2, w_en3;

    // stage 1: effective alpha
    t_chan       r1_a;
    logic        r1_zero;
    logic [31:0] r1_px;
    logic [15:0] n1_prod;
    logic [31:0] n1_px;

    // stage 2: mix sums live in the lanes
    logic        r2_zero;
    logic        r2_full;
    logic        r2_format;
    logic [31:0] r2_px;
    t_chan       w_d [4];
    t_chan       w_c [4];
    t_chan       w_q [4];

    // stage 3: output register
    logic [31:0] r3_pixel;
    logic        r3_write;
    logic [31:0] n3_pixel;

    assign w_rdy3 = !r_v3 || !i_stall;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_en1  = w_rdy1;
    assign w_en2  = w_rdy2;
    assign w_en3  = w_rdy3;

    assign o_stall     = !w_rdy1;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_RGB565;
            r_red    <= '0;
            r_green  <= '0;
            r_blue   <= '0;
            r_alpha  <= ALPHA_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FORMAT: r_format <= i_cfg_data[0];
                REG_RED:    r_red    <= i_cfg_data;
                REG_GREEN:  r_green  <= i_cfg_data;
                REG_BLUE:   r_blue   <= i_cfg_data;
                REG_ALPHA:  r_alpha  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // stage 1: a = (m * alpha + 128) >> 8; RGB565 ignores the upper half
    always_comb begin
        n1_prod = 16'(i_mask_alpha) * 16'(r_alpha) + 16'd128;
        n1_px   = (r_format == FMT_RGB565) ? {16'd0, i_dst_pixel[15:0]} : i_dst_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_a    <= n1_prod[15:8];
            r1_zero <= (i_mask_alpha == 8'd0);
            r1_px   <= n1_px;
        end
    end

    // stage 2: lane operands; lanes are B, G, R, A in RGBA8888 order
    always_comb begin
        if (r_format == FMT_RGBA8888) begin
            w_d[0] = r1_px[7:0];
            w_d[1] = r1_px[15:8];
            w_d[2] = r1_px[23:16];
            w_d[3] = r1_px[31:24];
        end else begin
            // bit replication up to 8 bits
            w_d[0] = {r1_px[4:0],   r1_px[4:2]};
            w_d[1] = {r1_px[10:5],  r1_px[10:9]};
            w_d[2] = {r1_px[15:11], r1_px[15:13]};
            w_d[3] = '0;
        end
        w_c[0] = r_blue;
        w_c[1] = r_green;
        w_c[2] = r_red;
        w_c[3] = CHAN_FULL;
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        a8mab_mix u_mix (
            .i_clk (i_clk),
            .i_en  (w_en2),
            .i_a   (r1_a),
            .i_c   (w_c[g]),
            .i_d   (w_d[g]),
            .o_q   (w_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_zero   <= r1_zero;
            r2_full   <= (r1_a == CHAN_FULL);
            r2_format <= r_format;
            r2_px     <= r1_px;
        end
    end

    // stage 3: select and pack
    always_comb begin
        if (r2_zero) begin
            n3_pixel = r2_px;
        end else if (r2_format == FMT_RGBA8888) begin
            n3_pixel = {w_q[3], w_q[2], w_q[1], w_q[0]};
        end else if (r2_full) begin
            // an effective alpha of 255 writes the colour straight through
            n3_pixel = {16'd0, pack_565(r_red, r_green, r_blue)};
        end else begin
            n3_pixel = {16'd0, pack_565(w_q[2], w_q[1], w_q[0])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_pixel <= n3_pixel;
            r3_write <= !r2_zero;
        end
    end

    assign o_valid        = r_v3;
    assign o_pixel_out    = r3_pixel;
    assign o_write_needed = r3_write;

endmodule

FILE: sv/a8mab_chk.sv
// Port-level checker for the blender, bound to the top level.
module a8mab_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_pixel_out,
    input logic        o_write_needed
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_out) && $stable(o_write_needed)))
        else $error("stalled result changed");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // backpressure only reaches the input once the output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // a pipe that is stalled at the input keeps its held result valid
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && i_valid) |=> o_valid)
        else $error("result lost while pipe full");

endmodule

bind a8_mask_alpha_blend a8mab_chk u_a8mab_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pixel_out    (o_pixel_out),
    .o_write_needed (o_write_needed)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the A8 mask alpha blender: directed and random pixels, checked live.
`timescale 1ns / 100ps

module tb_top;
    import a8mab_pkg::*;

    // Clock period is 8 ns; the run is cut off well past the slowest legal run.
    localparam int unsigned RESET_CYCLES  = 3;
    localparam int unsigned DRAIN_CYCLES  = 8;      // pipe is three stages deep
    localparam int unsigned PRESSURE_HOLD = 120;    // long receiver hold-off, in cycles
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_PIXELS  = 250;
    localparam int unsigned PRESSURE_PHASE = 3;

    // Indexes past the register list; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        t_chan       mask;
        logic [31:0] dst;
    } t_pixel_req;

    typedef struct {
        logic [31:0] pixel;
        logic        write_needed;
    } t_blend;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_chan                 i_mask_alpha = '0;
    logic [31:0]           i_dst_pixel = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [31:0]           o_pixel_out;
    logic                  o_write_needed;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Local copy of the colour/format registers, updated on each config transfer
    logic  cfg_format = FMT_RGB565;
    t_chan cfg_red    = '0;
    t_chan cfg_green  = '0;
    t_chan cfg_blue   = '0;
    t_chan cfg_alpha  = ALPHA_RESET;

    t_pixel_req pending_pixels[$];      // not yet offered to the block
    t_blend     expected_blends[$];     // accepted, result still owed
    t_pixel_req next_req;
    t_blend     oldest_blend;

    // Idling knobs, written only by the stimulus process
    bit          send_idle = 1'b0;
    bit          recv_idle = 1'b0;
    int unsigned long_holds_wanted = 0;
    int unsigned pixels_pushed = 0;

    // Owned by the driver / monitor processes respectively
    int unsigned send_gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned long_holds_done = 0;

    int unsigned error_count = 0;
    int unsigned results_checked = 0;
    int unsigned zero_mask_seen = 0;
    int unsigned backpressure_cycles = 0;
    int unsigned settings_used = 0;

    a8_mask_alpha_blend u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mask_alpha   (i_mask_alpha),
        .i_dst_pixel    (i_dst_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_out    (o_pixel_out),
        .o_write_needed (o_write_needed),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One channel of the source-over mix, rounded division by 255.
    function automatic t_chan mix_chan(input t_chan a, input t_chan c, input t_chan d);
        int acc;
        acc = (int'(a) * int'(c) + (255 - int'(a)) * int'(d) + 127) / 255;
        return acc[7:0];
    endfunction

    function automatic t_blend blend_pixel(input t_chan mask, input logic [31:0] dst);
        t_blend      res;
        logic [31:0] px;
        int          eff_alpha;
        t_chan       a, r, g, b;
        // RGB565 ignores the upper half of the word on the way in and zeroes it on the way out
        px = (cfg_format == FMT_RGB565) ? {16'h0000, dst[15:0]} : dst;
        res.pixel = px;
        res.write_needed = 1'b0;
        if (mask != 8'd0) begin
            eff_alpha = (int'(mask) * int'(cfg_alpha) + 128) >> 8;
            a = eff_alpha[7:0];
            res.write_needed = 1'b1;
            if (cfg_format == FMT_RGBA8888) begin
                // byte order B,G,R,A; alpha channel blends towards full
                res.pixel = {mix_chan(a, CHAN_FULL, px[31:24]), mix_chan(a, cfg_red, px[23:16]),
                             mix_chan(a, cfg_green, px[15:8]), mix_chan(a, cfg_blue, px[7:0])};
            end else begin
                // widen by bit replication, mix, then truncate back to 5/6/5.
                // a tops out at 254, and a mix at 255 would equal the direct colour
                // write anyway, so the full-alpha shortcut needs no branch here.
                r = mix_chan(a, cfg_red,   {px[15:11], px[15:13]});
                g = mix_chan(a, cfg_green, {px[10:5],  px[10:9]});
                b = mix_chan(a, cfg_blue,  {px[4:0],   px[4:2]});
                res.pixel = {16'h0000, r[7:3], g[7:2], b[7:3]};
            end
        end
        return res;
    endfunction

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int unsigned pick_gap(input bit busy);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!busy || roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: offers queued pixels, holds the payload while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap_left = 0;
        end else begin
            if (i_valid && !o_stall)
                expected_blends.push_back(blend_pixel(i_mask_alpha, i_dst_pixel));
            if (i_valid && o_stall) begin
                backpressure_cycles++;
            end else if (send_gap_left > 0) begin
                send_gap_left--;
                i_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                next_req = pending_pixels.pop_front();
                i_mask_alpha <= next_req.mask;
                i_dst_pixel  <= next_req.dst;
                i_valid      <= 1'b1;
                send_gap_left = pick_gap(send_idle);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each transfer against the oldest prediction
    // and drives the output stall, including the long pressure hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_blends.size() == 0) begin
                    $error("unexpected result transfer: pixel_out %h write_needed %b",
                           o_pixel_out, o_write_needed);
                    error_count++;
                end else begin
                    oldest_blend = expected_blends.pop_front();
                    if (o_pixel_out !== oldest_blend.pixel) begin
                        $error("pixel_out: expected %h, actual %h",
                               oldest_blend.pixel, o_pixel_out);
                        error_count++;
                    end
                    if (o_write_needed !== oldest_blend.write_needed) begin
                        $error("write_needed: expected %b, actual %b",
                               oldest_blend.write_needed, o_write_needed);
                        error_count++;
                    end
                    if (!oldest_blend.write_needed)
                        zero_mask_seen++;
                    results_checked++;
                end
            end
            // A requested long hold starts on the next live result so the pipe backs up
            if (stall_left == 0 && long_holds_done < long_holds_wanted && o_valid) begin
                stall_left = PRESSURE_HOLD;
                long_holds_done++;
            end else if (stall_left == 0) begin
                stall_left = pick_gap(recv_idle);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Register write over the config channel; the local copy follows the transfer.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FORMAT: cfg_format = val[0];
            REG_RED:    cfg_red    = val;
            REG_GREEN:  cfg_green  = val;
            REG_BLUE:   cfg_blue   = val;
            REG_ALPHA:  cfg_alpha  = val;
            default:    ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input t_chan mask, input logic [31:0] dst);
        t_pixel_req req;
        req.mask = mask;
        req.dst  = dst;
        pending_pixels.push_back(req);
        pixels_pushed++;
    endtask

    // Block until every queued pixel has come back, then let the pipe settle.
    task automatic wait_drained();
        while (results_checked < pixels_pushed)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Colour values lean on the extremes.
    function automatic t_chan pick_chan();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return t_chan'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_settings();
        write_reg(REG_FORMAT, t_chan'($urandom_range(0, 255)));  // only bit 0 should stick
        write_reg(REG_RED,    pick_chan());
        write_reg(REG_GREEN,  pick_chan());
        write_reg(REG_BLUE,   pick_chan());
        write_reg(REG_ALPHA,  pick_chan());
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), pick_chan());
        settings_used++;
    endtask

    initial begin
        t_chan       mask;
        logic [31:0] dst;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset colour: RGB565, black, alpha 255. Zero mask with junk in the upper half.
        settings_used++;
        push_pixel(8'd0,   32'hFFFF_FFFF);
        push_pixel(8'd0,   32'h0000_0000);
        push_pixel(8'd255, 32'hFFFF_FFFF);
        push_pixel(8'd255, 32'h0000_0000);
        push_pixel(8'd1,   32'h5555_AAAA);
        push_pixel(8'd128, 32'hAAAA_5555);
        push_pixel(8'd127, 32'h0000_F81F);
        wait_drained();

        // RGBA8888 via a wide format value, saturated red, half blue; spare indexes ignored
        write_reg(REG_FORMAT, 8'hFF);
        write_reg(REG_RED,    8'hFF);
        write_reg(REG_GREEN,  8'h00);
        write_reg(REG_BLUE,   8'h80);
        write_reg(REG_ALPHA,  8'hFF);
        write_reg(REG_SPARE_LO, 8'h00);
        write_reg(REG_SPARE_HI, 8'hFF);
        settings_used++;
        push_pixel(8'd0,   32'hFFFF_FFFF);
        push_pixel(8'd0,   32'h1234_5678);
        push_pixel(8'd255, 32'h0000_0000);
        push_pixel(8'd255, 32'hFFFF_FFFF);
        push_pixel(8'd1,   32'h00FF_00FF);
        push_pixel(8'd200, 32'h8080_8080);
        wait_drained();

        // Back to RGB565 (bit 0 clear in a wide value), zero colour alpha
        write_reg(REG_FORMAT, 8'hFE);
        write_reg(REG_RED,    8'h00);
        write_reg(REG_GREEN,  8'hFF);
        write_reg(REG_BLUE,   8'hFF);
        write_reg(REG_ALPHA,  8'h00);
        settings_used++;
        push_pixel(8'd255, 32'hFFFF_F0F0);
        push_pixel(8'd1,   32'h0000_07E0);
        push_pixel(8'd0,   32'hABCD_1234);
        wait_drained();

        // Colour alpha of one: smallest non-zero effective alpha at full coverage
        write_reg(REG_ALPHA, 8'h01);
        push_pixel(8'd255, 32'h0000_0000);
        push_pixel(8'd255, 32'h0000_FFFF);
        wait_drained();

        // Random phases. First runs flat out; the pressure phase streams with no
        // gaps while the receiver sits on one long hold-off.
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_settings();
            send_idle = (phase != 0 && phase != PRESSURE_PHASE);
            recv_idle = (phase != 0 && phase != PRESSURE_PHASE);
            if (phase == PRESSURE_PHASE)
                long_holds_wanted++;
            for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
                case ($urandom_range(0, 9))
                    0:       mask = 8'd0;
                    1:       mask = 8'd255;
                    2:       mask = 8'd1;
                    default: mask = t_chan'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 19) == 0)
                    dst = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                else
                    dst = $urandom();
                push_pixel(mask, dst);
            end
            wait_drained();
        end

        $display("checked %0d blended pixels (%0d with zero coverage) across %0d colour settings",
                 results_checked, zero_mask_seen, settings_used);
        $display("input held off by back-pressure for %0d cycles", backpressure_cycles);
        if (error_count == 0)
            $display("a8_mask_alpha_blend verification clean");
        else
            $display("a8_mask_alpha_blend verification failed");
        $finish;
    end

    // Hard stop: several times the slowest legal run
    initial begin
        #5_000_000;
        $display("a8_mask_alpha_blend verification failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/a8mab_pkg.sv
sv/a8mab_mix.sv
sv/a8_mask_alpha_blend.sv
sv/a8mab_chk.sv
sim/tb_top.sv
